// ----- rtl/core/aabb_pushout_and_ground_check_defines.svh -----
// assertion macros for the box push-out and ground check block
// used by the top level; expects clk_i and rst_ni in scope
`ifndef AABB_PUSHOUT_AND_GROUND_CHECK_DEFINES_SVH
`define AABB_PUSHOUT_AND_GROUND_CHECK_DEFINES_SVH

// same-cycle implication
`define APGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/apgc_pkg.sv -----
// shared types, constants and register indexes of the push-out block
// no dependencies
`default_nettype none
package apgc_pkg;

  localparam int CoordW        = 32;
  localparam int DefMaxObst    = 64;
  localparam int DefPushIter   = 4;
  localparam logic [CoordW-1:0] EpsQ = CoordW'(7);

  localparam logic [30:0] HalfReset = 31'd65536;
  localparam logic [30:0] GepsReset = 31'd655;

  typedef logic [CoordW-1:0]       coord_t;
  typedef logic [2:0][CoordW-1:0]  coord3_t;

  typedef struct packed {
    logic    active;
    coord3_t mn;
    coord3_t mx;
  } obst_t;

  typedef struct packed {
    coord3_t lo;
    coord3_t hi;
    coord3_t c;
  } box_t;

  typedef struct packed {
    logic   hit;
    logic   gnd;
  } test_t;

  typedef struct packed {
    logic [1:0] axis;
    logic       neg;
    coord_t     amt;
  } push_t;

  typedef enum logic [2:0] {
    REG_OFFSET_X  = 3'd0,
    REG_OFFSET_Y  = 3'd1,
    REG_OFFSET_Z  = 3'd2,
    REG_HALF_X    = 3'd3,
    REG_HALF_Y    = 3'd4,
    REG_HALF_Z    = 3'd5,
    REG_GROUND    = 3'd6,
    REG_BOX_COUNT = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_PUSH,
    ST_DONE
  } state_e;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/core/aabb_pushout_and_ground_check.sv -----
// a load answers with a registered done strobe; a resolve runs up to PUSH_ITERATIONS+1 passes,
//   fewer when a pass finds no hit
// throughput: one resolve at a time; the obstacle ring turns once per pass through
//   a single test unit at its head, with setup and push states around the scan
// loads may follow one another every cycle while no resolve is busy; results cannot be stalled
// reset clears all active bits, the configuration registers and the control state; obstacle corners are not reset
`default_nettype none
`include "aabb_pushout_and_ground_check_defines.svh"
module aabb_pushout_and_ground_check import apgc_pkg::*; #(
  parameter int MAX_OBSTACLES   = DefMaxObst,
  parameter int PUSH_ITERATIONS = DefPushIter
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         opcode_i,
  input  wire  [5:0]  entry_index_i,
  input  wire         entry_active_i,
  input  wire  [31:0] entry_min_x_i,
  input  wire  [31:0] entry_min_y_i,
  input  wire  [31:0] entry_min_z_i,
  input  wire  [31:0] entry_max_x_i,
  input  wire  [31:0] entry_max_y_i,
  input  wire  [31:0] entry_max_z_i,
  input  wire  [31:0] pos_x_i,
  input  wire  [31:0] pos_y_i,
  input  wire  [31:0] pos_z_i,
  output logic        done_o,
  output logic [31:0] new_pos_x_o,
  output logic [31:0] new_pos_y_o,
  output logic [31:0] new_pos_z_o,
  output logic        grounded_o,
  output logic [2:0]  pushes_done_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int StepW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int PassW = $clog2(PUSH_ITERATIONS + 1);

  // configuration registers
  coord3_t     off_q;
  logic [2:0][30:0] half_q;
  logic [30:0] geps_q;
  logic [6:0]  box_count_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      half_q      <= {3{HalfReset}};
      geps_q      <= GepsReset;
      box_count_q <= '0;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[4:2]))
        REG_OFFSET_X:  off_q[0]    <= pwdata;
        REG_OFFSET_Y:  off_q[1]    <= pwdata;
        REG_OFFSET_Z:  off_q[2]    <= pwdata;
        REG_HALF_X:    half_q[0]   <= pwdata[30:0];
        REG_HALF_Y:    half_q[1]   <= pwdata[30:0];
        REG_HALF_Z:    half_q[2]   <= pwdata[30:0];
        REG_GROUND:    geps_q      <= pwdata[30:0];
        REG_BOX_COUNT: box_count_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_OFFSET_X:  prdata = off_q[0];
      REG_OFFSET_Y:  prdata = off_q[1];
      REG_OFFSET_Z:  prdata = off_q[2];
      REG_HALF_X:    prdata = {1'b0, half_q[0]};
      REG_HALF_Y:    prdata = {1'b0, half_q[1]};
      REG_HALF_Z:    prdata = {1'b0, half_q[2]};
      REG_GROUND:    prdata = {1'b0, geps_q};
      REG_BOX_COUNT: prdata = {25'd0, box_count_q};
      default:       prdata = '0;
    endcase
  end

  // control state
  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [PassW-1:0] pass_q, pass_d;
  logic gmode_q, gmode_d, hit_q, hit_d, gnd_q, gnd_d;
  logic [2:0] pushes_q, pushes_d;
  coord3_t p_q, p_d;
  box_t    box_q, box_d;
  obst_t   hent_q, hent_d;
  logic    done_q, done_d;
  coord3_t res_pos_q, res_pos_d;
  logic    res_gnd_q, res_gnd_d;
  logic [2:0] res_push_q, res_push_d;

  // obstacle ring
  obst_t ring [MAX_OBSTACLES];
  obst_t load_ent;
  logic  do_load, shift_en;

  assign load_ent = '{active: entry_active_i,
                      mn: {entry_min_z_i, entry_min_y_i, entry_min_x_i},
                      mx: {entry_max_z_i, entry_max_y_i, entry_max_x_i}};
  assign do_load  = start_i && !busy_o && (opcode_i == OP_LOAD);
  assign shift_en = (state_q == ST_SCAN);

  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    apgc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (do_load && ({26'd0, entry_index_i} == 32'(i))),
      .load_data_i  (load_ent),
      .shift_i      (shift_en),
      .shift_data_i (ring[(i == MAX_OBSTACLES - 1) ? 0 : i + 1]),
      .data_o       (ring[i])
    );
  end

  test_t head_test;
  push_t push;

  apgc_eval u_eval (
    .ent_i        (ring[0]),
    .box_i        (box_q),
    .ground_eps_i (geps_q),
    .test_o       (head_test)
  );

  apgc_push u_push (
    .ent_i  (hent_q),
    .box_i  (box_q),
    .push_o (push)
  );

  logic in_range;
  assign in_range = (32'(box_count_q) > 32'(step_q)) && ring[0].active;
  assign busy_o   = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      pass_q   <= '0;
      gmode_q  <= 1'b0;
      hit_q    <= 1'b0;
      gnd_q    <= 1'b0;
      pushes_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pass_q   <= pass_d;
      gmode_q  <= gmode_d;
      hit_q    <= hit_d;
      gnd_q    <= gnd_d;
      pushes_q <= pushes_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    box_q      <= box_d;
    hent_q     <= hent_d;
    res_pos_q  <= res_pos_d;
    res_gnd_q  <= res_gnd_d;
    res_push_q <= res_push_d;
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    pass_d     = pass_q;
    gmode_d    = gmode_q;
    hit_d      = hit_q;
    gnd_d      = gnd_q;
    pushes_d   = pushes_q;
    p_d        = p_q;
    box_d      = box_q;
    hent_d     = hent_q;
    done_d     = 1'b0;
    res_pos_d  = res_pos_q;
    res_gnd_d  = res_gnd_q;
    res_push_d = res_push_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_LOAD) begin
            done_d     = 1'b1;
            res_pos_d  = '0;
            res_gnd_d  = 1'b0;
            res_push_d = '0;
          end else begin
            p_d      = {pos_z_i, pos_y_i, pos_x_i};
            pass_d   = '0;
            gmode_d  = 1'b0;
            gnd_d    = 1'b0;
            pushes_d = '0;
            state_d  = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        for (int k = 0; k < 3; k++) begin
          box_d.c[k]  = p_q[k] + off_q[k];
          box_d.lo[k] = box_d.c[k] - CoordW'(half_q[k]);
          box_d.hi[k] = box_d.c[k] + CoordW'(half_q[k]);
        end
        hit_d   = 1'b0;
        step_d  = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (in_range) begin
          if (!gmode_q && !hit_q && head_test.hit) begin
            hit_d  = 1'b1;
            hent_d = ring[0];
          end
          if (gmode_q && head_test.gnd) begin
            gnd_d = 1'b1;
          end
        end
        step_d = step_q + StepW'(1);
        // the ring is back home after a full turn
        if (step_q == StepW'(MAX_OBSTACLES - 1)) begin
          step_d = '0;
          if (gmode_q) begin
            state_d = ST_DONE;
          end else if (hit_d) begin
            state_d = ST_PUSH;
          end else begin
            gmode_d = 1'b1;
          end
        end
      end
      ST_PUSH: begin
        if (push.neg) begin
          p_d[push.axis] = p_q[push.axis] - push.amt;
        end else begin
          p_d[push.axis] = p_q[push.axis] + push.amt;
        end
        if (pushes_q != 3'd7) begin
          pushes_d = pushes_q + 3'd1;
        end
        pass_d = pass_q + PassW'(1);
        if (pass_d == PassW'(PUSH_ITERATIONS)) begin
          gmode_d = 1'b1;
        end
        state_d = ST_PREP;
      end
      ST_DONE: begin
        done_d     = 1'b1;
        res_pos_d  = p_q;
        res_gnd_d  = gnd_q;
        res_push_d = pushes_q;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_o        = done_q;
  assign new_pos_x_o   = res_pos_q[0];
  assign new_pos_y_o   = res_pos_q[1];
  assign new_pos_z_o   = res_pos_q[2];
  assign grounded_o    = res_gnd_q;
  assign pushes_done_o = res_push_q;

  `APGC_ASSERT_NEXT(a_load_result, start_i && !busy_o && opcode_i == OP_LOAD, done_o, "load gave no result")
  `APGC_ASSERT_NOW(a_push_after_hit, state_q == ST_PUSH, hit_q && !gmode_q, "push without a captured hit")
  `APGC_ASSERT_NOW(a_pass_bound, state_q == ST_SCAN && !gmode_q, 32'(pass_q) < PUSH_ITERATIONS, "push pass beyond limit")
  `APGC_ASSERT_NEXT(a_done_to_idle, state_q == ST_DONE, done_o && !busy_o, "resolve result missing")

endmodule
`default_nettype wire

// ----- rtl/core/apgc_cell.sv -----
// one obstacle cell of the rotating table
// depends on apgc_pkg
`default_nettype none
module apgc_cell import apgc_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   load_i,
  input  obst_t load_data_i,
  input  wire   shift_i,
  input  obst_t shift_data_i,
  output obst_t data_o
);

  logic    active_q;
  coord3_t mn_q, mx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (load_i) begin
      active_q <= load_data_i.active;
    end else if (shift_i) begin
      active_q <= shift_data_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mn_q <= load_data_i.mn;
      mx_q <= load_data_i.mx;
    end else if (shift_i) begin
      mn_q <= shift_data_i.mn;
      mx_q <= shift_data_i.mx;
    end
  end

  assign data_o = '{active: active_q, mn: mn_q, mx: mx_q};

endmodule
`default_nettype wire

// ----- rtl/core/apgc_eval.sv -----
// intersection and ground tests of the body box against the head cell
// depends on apgc_pkg
`default_nettype none
module apgc_eval import apgc_pkg::*; (
  input  obst_t       ent_i,
  input  box_t        box_i,
  input  wire  [30:0] ground_eps_i,
  output test_t       test_o
);

  logic [2:0] ov;
  coord_t     dy;
  logic signed [CoordW:0] dy_w, eps_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ov[k] = ($signed(box_i.hi[k]) > $signed(ent_i.mn[k])) &&
              ($signed(box_i.lo[k]) < $signed(ent_i.mx[k]));
    end
    dy    = box_i.lo[1] - ent_i.mx[1];
    dy_w  = $signed({dy[CoordW-1], dy});
    eps_w = $signed((CoordW+1)'(ground_eps_i));
    test_o.hit = &ov;
    // bottom of the body within tolerance of the obstacle top
    test_o.gnd = ov[0] && ov[2] && (dy_w >= -eps_w) && (dy_w <= eps_w);
  end

endmodule
`default_nettype wire

// ----- rtl/core/apgc_push.sv -----
// smallest-overlap push direction and amount for the captured obstacle
// depends on apgc_pkg
`default_nettype none
module apgc_push import apgc_pkg::*; (
  input  obst_t ent_i,
  input  box_t  box_i,
  output push_t push_o
);

  coord3_t ov;
  coord_t  d1, d2, best;
  logic [1:0] ax;
  logic signed [CoordW:0] c2, sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1 = ent_i.mx[k] - box_i.lo[k];
      d2 = box_i.hi[k] - ent_i.mn[k];
      ov[k] = ($signed(d1) < $signed(d2)) ? d1 : d2;
    end
    best = ov[0];
    ax   = 2'd0;
    // ties stay on the earlier axis
    if ($signed(ov[1]) < $signed(best)) begin
      best = ov[1];
      ax   = 2'd1;
    end
    if ($signed(ov[2]) < $signed(best)) begin
      best = ov[2];
      ax   = 2'd2;
    end
    // centres compared doubled so no halving is needed
    c2  = $signed({box_i.c[ax], 1'b0});
    sum = $signed({ent_i.mn[ax][CoordW-1], ent_i.mn[ax]}) +
          $signed({ent_i.mx[ax][CoordW-1], ent_i.mx[ax]});
    push_o.axis = ax;
    push_o.neg  = c2 < sum;
    push_o.amt  = best + EpsQ;
  end

endmodule
`default_nettype wire

// ----- tb/apgc_checker.sv -----
// scoreboard for the box push-out and ground check block: mirrors the registers and the
// obstacle table, predicts each word's result and compares it with the done strobe
// depends on apgc_pkg for the register indexes and opcodes
`default_nettype none
module apgc_checker import apgc_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire         busy_o,
  input  wire         opcode_i,
  input  wire  [5:0]  entry_index_i,
  input  wire         entry_active_i,
  input  wire  [31:0] entry_min_x_i,
  input  wire  [31:0] entry_min_y_i,
  input  wire  [31:0] entry_min_z_i,
  input  wire  [31:0] entry_max_x_i,
  input  wire  [31:0] entry_max_y_i,
  input  wire  [31:0] entry_max_z_i,
  input  wire  [31:0] pos_x_i,
  input  wire  [31:0] pos_y_i,
  input  wire  [31:0] pos_z_i,
  input  wire         done_o,
  input  wire  [31:0] new_pos_x_o,
  input  wire  [31:0] new_pos_y_o,
  input  wire  [31:0] new_pos_z_o,
  input  wire         grounded_o,
  input  wire  [2:0]  pushes_done_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  input  wire         pready,
  output int          fails_o,
  output int          pending_o,
  output int          n_resolved_o,
  output int          n_grounded_o,
  output int          n_pushed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumObst = 64;
  localparam int NumPass = 4;
  localparam logic signed [31:0] PushEps = 32'sd7;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        gnd;
    logic [2:0]  pushes;
  } body_res_t;

  body_res_t expected_q[$];

  logic signed [31:0] off_x, off_y, off_z;
  logic [30:0]        half_x, half_y, half_z, gnd_eps;
  logic [6:0]         box_cnt;

  logic signed [31:0] tab_mn [NumObst][3];
  logic signed [31:0] tab_mx [NumObst][3];
  logic               tab_act [NumObst];

  int fails, resolved, grounded_cnt, pushed_cnt;

  assign fails_o      = fails;
  assign pending_o    = expected_q.size();
  assign n_resolved_o = resolved;
  assign n_grounded_o = grounded_cnt;
  assign n_pushed_o   = pushed_cnt;

  function automatic body_res_t resolve_body(input logic [31:0] px, py, pz);
    logic signed [31:0] p [3];
    logic signed [31:0] off [3];
    logic signed [31:0] hs [3];
    logic signed [31:0] c [3];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] bmn [3];
    logic signed [31:0] bmx [3];
    logic signed [31:0] ov [3];
    logic signed [31:0] d1, d2, push, amt, dy;
    int n, ax, npush;
    logic hit, gnd;
    body_res_t r;
    p[0] = px; p[1] = py; p[2] = pz;
    off[0] = off_x; off[1] = off_y; off[2] = off_z;
    hs[0] = {1'b0, half_x}; hs[1] = {1'b0, half_y}; hs[2] = {1'b0, half_z};
    n = (box_cnt > NumObst) ? NumObst : int'(box_cnt);
    npush = 0;
    for (int it = 0; it <= NumPass; it++) begin
      hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
        c[k]  = p[k] + off[k];
        lo[k] = c[k] - hs[k];
        hi[k] = c[k] + hs[k];
      end
      if (it == NumPass) break;
      for (int i = 0; i < n && !hit; i++) begin
        if (tab_act[i]) begin
          for (int k = 0; k < 3; k++) begin
            bmn[k] = tab_mn[i][k];
            bmx[k] = tab_mx[i][k];
          end
          if (hi[0] > bmn[0] && lo[0] < bmx[0] && hi[1] > bmn[1] && lo[1] < bmx[1] &&
              hi[2] > bmn[2] && lo[2] < bmx[2]) begin
            for (int k = 0; k < 3; k++) begin
              d1 = bmx[k] - lo[k];
              d2 = hi[k] - bmn[k];
              ov[k] = (d1 < d2) ? d1 : d2;
            end
            ax = 0;
            push = ov[0];
            if (ov[1] < push) begin
              push = ov[1];
              ax = 1;
            end
            if (ov[2] < push) begin
              push = ov[2];
              ax = 2;
            end
            amt = push + PushEps;
            // centre side decided on doubled sums so no halving is needed
            if (2 * longint'(c[ax]) < longint'(bmn[ax]) + longint'(bmx[ax])) p[ax] = p[ax] - amt;
            else p[ax] = p[ax] + amt;
            hit = 1'b1;
          end
        end
      end
      if (!hit) break;
      if (npush < 7) npush++;
    end
    gnd = 1'b0;
    for (int i = 0; i < n && !gnd; i++) begin
      if (tab_act[i] && hi[0] > tab_mn[i][0] && lo[0] < tab_mx[i][0] &&
          hi[2] > tab_mn[i][2] && lo[2] < tab_mx[i][2]) begin
        dy = lo[1] - tab_mx[i][1];
        if (longint'(dy) >= -longint'(gnd_eps) && longint'(dy) <= longint'(gnd_eps)) gnd = 1'b1;
      end
    end
    r.x = p[0];
    r.y = p[1];
    r.z = p[2];
    r.gnd = gnd;
    r.pushes = 3'(npush);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    body_res_t exp_r;
    if (!rst_ni) begin
      off_x <= '0; off_y <= '0; off_z <= '0;
      half_x <= 31'd65536; half_y <= 31'd65536; half_z <= 31'd65536;
      gnd_eps <= 31'd655;
      box_cnt <= '0;
      for (int i = 0; i < NumObst; i++) tab_act[i] <= 1'b0;
      expected_q.delete();
      fails <= 0; resolved <= 0; grounded_cnt <= 0; pushed_cnt <= 0;
    end else begin
      // results first: a word accepted now cannot finish in the same cycle
      if (done_o) begin
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("[%0t] result word with nothing expected", $realtime);
          fails <= fails + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.x !== new_pos_x_o || exp_r.y !== new_pos_y_o || exp_r.z !== new_pos_z_o ||
              exp_r.gnd !== grounded_o || exp_r.pushes !== pushes_done_o) begin
            if (fails < 10)
              $display("[%0t] mismatch exp x=%h y=%h z=%h g=%b n=%0d got x=%h y=%h z=%h g=%b n=%0d",
                       $realtime, exp_r.x, exp_r.y, exp_r.z, exp_r.gnd, exp_r.pushes,
                       new_pos_x_o, new_pos_y_o, new_pos_z_o, grounded_o, pushes_done_o);
            fails <= fails + 1;
          end
          if (grounded_o === 1'b1) grounded_cnt <= grounded_cnt + 1;
          if (pushes_done_o !== 3'd0) pushed_cnt <= pushed_cnt + 1;
        end
      end
      if (start_i && !busy_o) begin
        if (opcode_i == OP_LOAD) begin
          expected_q.push_back('0);
          tab_act[entry_index_i] <= entry_active_i;
          tab_mn[entry_index_i][0] <= entry_min_x_i;
          tab_mn[entry_index_i][1] <= entry_min_y_i;
          tab_mn[entry_index_i][2] <= entry_min_z_i;
          tab_mx[entry_index_i][0] <= entry_max_x_i;
          tab_mx[entry_index_i][1] <= entry_max_y_i;
          tab_mx[entry_index_i][2] <= entry_max_z_i;
        end else begin
          expected_q.push_back(resolve_body(pos_x_i, pos_y_i, pos_z_i));
          resolved <= resolved + 1;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[4:2]))
          REG_OFFSET_X:  off_x <= pwdata;
          REG_OFFSET_Y:  off_y <= pwdata;
          REG_OFFSET_Z:  off_z <= pwdata;
          REG_HALF_X:    half_x <= pwdata[30:0];
          REG_HALF_Y:    half_y <= pwdata[30:0];
          REG_HALF_Z:    half_z <= pwdata[30:0];
          REG_GROUND:    gnd_eps <= pwdata[30:0];
          REG_BOX_COUNT: box_cnt <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_aabb_pushout_and_ground_check.sv -----
// top of the push-out block testbench: clock, reset, register setup and obstacle/body stimulus
// depends on apgc_pkg, the block itself and apgc_checker
`default_nettype none
module tb_aabb_pushout_and_ground_check;
  import apgc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases = 6;
  localparam int PhaseWords = 272;
  localparam int QuietWords = 150;
  localparam int Unit = 65536;

  logic        clk_i, rst_ni, start_i, opcode_i, entry_active_i;
  logic [5:0]  entry_index_i;
  logic [31:0] entry_min_x_i, entry_min_y_i, entry_min_z_i;
  logic [31:0] entry_max_x_i, entry_max_y_i, entry_max_z_i;
  logic [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  wire         busy_o, done_o, grounded_o, pready;
  wire  [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o, prdata;
  wire  [2:0]  pushes_done_o;
  int          fails, pending, n_resolved, n_grounded, n_pushed;

  // shadow of what was loaded and configured, used to aim the bodies and pick table indexes
  logic signed [31:0] shd_mn [64][3];
  logic signed [31:0] shd_mx [64][3];
  logic               shd_known [64];
  logic signed [31:0] cur_off_y;
  logic [31:0]        cur_half_y, cur_eps;
  int                 cur_cnt, words_sent, quiet_from;

  aabb_pushout_and_ground_check u_top (.*);

  apgc_checker u_checker (
    .fails_o(fails), .pending_o(pending), .n_resolved_o(n_resolved),
    .n_grounded_o(n_grounded), .n_pushed_o(n_pushed), .*
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic apb_write(input reg_e r, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0;
    case (r)
      REG_OFFSET_Y:  cur_off_y = v;
      REG_HALF_Y:    cur_half_y = {1'b0, v[30:0]};
      REG_GROUND:    cur_eps = {1'b0, v[30:0]};
      REG_BOX_COUNT: cur_cnt = (v[6:0] > 64) ? 64 : int'(v[6:0]);
      default: ;
    endcase
  endtask

  task automatic send_word(input logic op, input logic [5:0] idx, input logic act,
                           input logic [31:0] mnx, mny, mnz, mxx, mxy, mxz, px, py, pz);
    start_i <= 1'b1; opcode_i <= op; entry_index_i <= idx; entry_active_i <= act;
    entry_min_x_i <= mnx; entry_min_y_i <= mny; entry_min_z_i <= mnz;
    entry_max_x_i <= mxx; entry_max_y_i <= mxy; entry_max_z_i <= mxz;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    do @(posedge clk_i); while (busy_o);
    words_sent++;
    if (words_sent < quiet_from && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic load_box(input logic [5:0] idx, input logic act,
                          input logic [31:0] mnx, mny, mnz, mxx, mxy, mxz);
    shd_mn[idx][0] = mnx; shd_mn[idx][1] = mny; shd_mn[idx][2] = mnz;
    shd_mx[idx][0] = mxx; shd_mx[idx][1] = mxy; shd_mx[idx][2] = mxz;
    shd_known[idx] = 1'b1;
    send_word(OP_LOAD, idx, act, mnx, mny, mnz, mxx, mxy, mxz,
              $urandom, $urandom, $urandom);
  endtask

  task automatic resolve_at(input logic [31:0] px, py, pz);
    send_word(OP_RESOLVE, 6'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, px, py, pz);
  endtask

  function automatic logic [31:0] near(input int r);
    return $urandom_range(0, 2 * r) - r;
  endfunction

  // waits until every expected result has come back before the registers change
  task automatic drain;
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic random_word;
    logic [31:0] a, b, s;
    int i, sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      i = (cur_cnt > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, cur_cnt - 1)
                                                    : $urandom_range(0, 63);
      if ($urandom_range(0, 19) == 0) begin
        load_box(6'(i), 1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
      end else begin
        a = near(8 * Unit); b = near(8 * Unit); s = near(8 * Unit);
        load_box(6'(i), $urandom_range(0, 6) != 0, a, b, s,
                 a + $urandom_range(Unit / 2, 4 * Unit), b + $urandom_range(Unit / 2, 4 * Unit),
                 s + $urandom_range(Unit / 2, 4 * Unit));
      end
    end else begin
      i = (cur_cnt > 0) ? $urandom_range(0, cur_cnt - 1) : 0;
      if (sel < 75 && shd_known[i]) begin
        a = shd_mn[i][0] + $urandom_range(0, shd_mx[i][0] - shd_mn[i][0]);
        s = shd_mn[i][2] + $urandom_range(0, shd_mx[i][2] - shd_mn[i][2]);
        if ($urandom_range(0, 1) == 0) begin
          // body bottom placed around the top face, inside and just outside the tolerance
          b = shd_mx[i][1] + cur_half_y - cur_off_y + near(2 * cur_eps + 2);
        end else begin
          b = shd_mn[i][1] + $urandom_range(0, shd_mx[i][1] - shd_mn[i][1]);
        end
        resolve_at(a, b, s);
      end else if (sel < 92) begin
        resolve_at(near(10 * Unit), near(10 * Unit), near(10 * Unit));
      end else begin
        resolve_at($urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic set_phase(input int ph);
    case (ph)
      0: begin
        apb_write(REG_BOX_COUNT, 16);
      end
      1: begin
        apb_write(REG_OFFSET_X, near(2 * Unit));
        apb_write(REG_OFFSET_Y, near(2 * Unit));
        apb_write(REG_OFFSET_Z, near(2 * Unit));
        apb_write(REG_HALF_X, $urandom_range(Unit / 4, 3 * Unit));
        apb_write(REG_HALF_Y, $urandom_range(Unit / 4, 3 * Unit));
        apb_write(REG_HALF_Z, $urandom_range(Unit / 4, 3 * Unit));
        apb_write(REG_GROUND, $urandom_range(0, 4000));
        apb_write(REG_BOX_COUNT, $urandom_range(1, 64));
      end
      2: begin
        apb_write(REG_OFFSET_X, 32'h7fff_ffff);
        apb_write(REG_OFFSET_Y, 32'h8000_0000);
        apb_write(REG_OFFSET_Z, 32'h7fff_ffff);
        apb_write(REG_HALF_X, 32'hffff_ffff);
        apb_write(REG_HALF_Y, 32'h0000_0000);
        apb_write(REG_HALF_Z, 32'h7fff_ffff);
        apb_write(REG_GROUND, 32'hffff_ffff);
        apb_write(REG_BOX_COUNT, 127);
      end
      3: begin
        apb_write(REG_OFFSET_X, 32'h8000_0000);
        apb_write(REG_OFFSET_Y, 32'h7fff_ffff);
        apb_write(REG_OFFSET_Z, 32'h8000_0000);
        apb_write(REG_HALF_X, 0);
        apb_write(REG_HALF_Y, 32'h7fff_ffff);
        apb_write(REG_HALF_Z, 0);
        apb_write(REG_GROUND, 0);
        apb_write(REG_BOX_COUNT, 0);
      end
      4: begin
        for (int r = 0; r < 7; r++) apb_write(reg_e'(r), $urandom);
        apb_write(REG_BOX_COUNT, $urandom_range(0, 127));
      end
      default: begin
        apb_write(REG_OFFSET_X, 0);
        apb_write(REG_OFFSET_Y, near(Unit));
        apb_write(REG_OFFSET_Z, 0);
        apb_write(REG_HALF_X, Unit);
        apb_write(REG_HALF_Y, 2 * Unit);
        apb_write(REG_HALF_Z, Unit / 2);
        apb_write(REG_GROUND, 655);
        apb_write(REG_BOX_COUNT, 64);
      end
    endcase
  endtask

  initial begin
    rst_ni <= 1'b0; start_i <= 1'b0; opcode_i <= OP_LOAD; entry_index_i <= '0;
    entry_active_i <= 1'b0;
    entry_min_x_i <= '0; entry_min_y_i <= '0; entry_min_z_i <= '0;
    entry_max_x_i <= '0; entry_max_y_i <= '0; entry_max_z_i <= '0;
    pos_x_i <= '0; pos_y_i <= '0; pos_z_i <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    for (int i = 0; i < 64; i++) shd_known[i] = 1'b0;
    cur_off_y = 0; cur_half_y = Unit; cur_eps = 655; cur_cnt = 0;
    words_sent = 0;
    quiet_from = 20 + NumPhases * PhaseWords - QuietWords;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, then a floor, a wall, a pillar and some odd boxes
    resolve_at(0, 0, 0);
    load_box(0, 1'b1, -10 * Unit, -Unit, -10 * Unit, 10 * Unit, 0, 10 * Unit);
    load_box(1, 1'b1, 2 * Unit, 0, -Unit, 3 * Unit, 4 * Unit, Unit);
    load_box(2, 1'b0, -Unit, -Unit, -Unit, Unit, Unit, Unit);
    load_box(3, 1'b1, -Unit / 2, Unit, 4 * Unit, Unit / 2, 3 * Unit, 5 * Unit);
    load_box(63, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    load_box(62, 1'b1, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0, 32'hffff_ffff);
    drain();
    apb_write(REG_BOX_COUNT, 4);
    resolve_at(0, Unit, 0);
    resolve_at(0, Unit + 300, 0);
    resolve_at(0, Unit + 700, 0);
    resolve_at(0, Unit / 2, 0);
    resolve_at(2 * Unit + 100, 2 * Unit, 0);
    resolve_at(0, 2 * Unit, 4 * Unit + 10);
    resolve_at(0, 3 * Unit, 0);
    resolve_at(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    resolve_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    apb_write(REG_BOX_COUNT, 64);
    resolve_at(0, 0, 0);
    resolve_at(32'hffff_ffff, 32'h0000_0001, 32'h7fff_0000);
    load_box(63, 1'b0, 0, 0, 0, 0, 0, 0);
    load_box(62, 1'b0, 0, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      set_phase(ph);
      for (int w = 0; w < PhaseWords; w++) random_word();
    end

    drain();
    repeat (400) @(posedge clk_i);
    $display("covered %0d words, %0d resolves, %0d with pushes, %0d grounded, over %0d phases",
             words_sent, n_resolved, n_pushed, n_grounded, NumPhases + 1);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/apgc_pkg.sv
rtl/core/apgc_cell.sv
rtl/core/apgc_eval.sv
rtl/core/apgc_push.sv
rtl/core/aabb_pushout_and_ground_check.sv
tb/apgc_checker.sv
tb/tb_aabb_pushout_and_ground_check.sv
